// File: hw/rtl/ordered_keyed_record_table_macros.svh
// Assertion macros used by the record table checker.
`ifndef ORDERED_KEYED_RECORD_TABLE_MACROS_SVH
`define ORDERED_KEYED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define OKRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define OKRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/okrt_pkg.sv
// Shared constants, codes and record type for the ordered record table.
package okrt_pkg;

	// Table depth and derived widths
	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);

	// Request function codes
	localparam logic [2:0] FN_APPEND = 3'd0;
	localparam logic [2:0] FN_DELETE = 3'd1;
	localparam logic [2:0] FN_UPDATE = 3'd2;
	localparam logic [2:0] FN_LOOKUP = 3'd3;
	localparam logic [2:0] FN_DUMP   = 3'd4;
	localparam logic [2:0] FN_SCAN   = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NONE      = 2'd3;

	// One stored record
	typedef struct packed {
		logic [15:0] key;
		logic [15:0] count;
	} rec_t;

endpackage

// File: hw/rtl/okrt_cell.sv
// One storage cell of the record ring: loads its right-hand neighbour when shifted.
module okrt_cell (
	input  logic          clk,
	input  logic          shift,
	input  okrt_pkg::rec_t din,
	output okrt_pkg::rec_t dout
);

	okrt_pkg::rec_t rec_q;

	// Record payload, no reset needed
	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= din;
		end
	end

	assign dout = rec_q;

endmodule

// File: hw/rtl/okrt_ctrl.sv
// Sequencer for the record ring: walks each request over the head cell and forms results.
module okrt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    func,
	input  logic [15:0]                   search_key,
	input  logic [15:0]                   new_key,
	input  logic [15:0]                   new_count,
	input  logic [15:0]                   threshold,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [15:0]                   rec_key,
	output logic [15:0]                   rec_count,
	output logic                          last,
	input  okrt_pkg::rec_t                head,
	output okrt_pkg::rec_t                push,
	output logic [okrt_pkg::DEPTH-1:0]    shift_en
);

	localparam int IDX_W = okrt_pkg::IDX_W;
	localparam int OCC_W = okrt_pkg::OCC_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ROT  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [2:0]       func_q;
	logic [15:0]      skey_q;
	logic [15:0]      nkey_q;
	logic [15:0]      ncnt_q;
	logic [15:0]      thr_q;
	logic [OCC_W-1:0] occ_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] pos_q;
	logic             found_q;
	okrt_pkg::rec_t   frec_q;
	okrt_pkg::rec_t   hold_q;
	logic             have_q;
	logic             out_vld_q;
	logic [1:0]       status_q;
	logic [15:0]      key_q;
	logic [15:0]      count_q;
	logic             last_q;

	logic           adv;
	logic           in_rng;
	logic           hit;
	logic           qual;
	logic           is_srch;
	logic           is_list;
	logic           rot;
	logic           cls;
	logic           emit;
	okrt_pkg::rec_t new_rec;

	// Per-step decisions on the record at the head of the ring
	always_comb begin
		adv     = !out_vld_q || out_ready;
		in_rng  = OCC_W'(step_q) < occ_q;
		hit     = in_rng && !found_q && (head.key == skey_q);
		qual    = in_rng && ((func_q == okrt_pkg::FN_DUMP) || (head.count <= thr_q));
		is_srch = (func_q == okrt_pkg::FN_DELETE) || (func_q == okrt_pkg::FN_UPDATE) ||
			(func_q == okrt_pkg::FN_LOOKUP);
		is_list = (func_q == okrt_pkg::FN_DUMP) || (func_q == okrt_pkg::FN_SCAN);
		new_rec = '{key: nkey_q, count: ncnt_q};
		push    = head;
		if ((func_q == okrt_pkg::FN_APPEND) && (OCC_W'(step_q) == occ_q)) begin
			push = new_rec;
		end
		if ((func_q == okrt_pkg::FN_UPDATE) && hit) begin
			push = new_rec;
		end
		rot = (state_q == S_ROT) && adv;
		cls = (state_q == S_FIN) && adv && (func_q == okrt_pkg::FN_DELETE) && found_q;
		// a result is loaded mid-walk for a held list record, or at the finish
		emit = (rot && is_list && qual && have_q) || ((state_q == S_FIN) && adv);
		for (int i = 0; i < okrt_pkg::DEPTH; i++) begin
			shift_en[i] = rot || (cls && (IDX_W'(i) >= pos_q));
		end
	end

	// Request capture, ring walk and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			func_q    <= okrt_pkg::FN_APPEND;
			skey_q    <= '0;
			nkey_q    <= '0;
			ncnt_q    <= '0;
			thr_q     <= '0;
			occ_q     <= '0;
			step_q    <= '0;
			pos_q     <= '0;
			found_q   <= 1'b0;
			frec_q    <= '0;
			hold_q    <= '0;
			have_q    <= 1'b0;
			out_vld_q <= 1'b0;
			status_q  <= okrt_pkg::ST_OK;
			key_q     <= '0;
			count_q   <= '0;
			last_q    <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					// unused function codes are dropped without a result
					if (in_valid && (func <= okrt_pkg::FN_SCAN)) begin
						func_q  <= func;
						skey_q  <= search_key;
						nkey_q  <= new_key;
						ncnt_q  <= new_count;
						thr_q   <= threshold;
						step_q  <= '0;
						found_q <= 1'b0;
						have_q  <= 1'b0;
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					if (adv) begin
						if (is_srch && hit) begin
							found_q <= 1'b1;
							pos_q   <= step_q;
							frec_q  <= (func_q == okrt_pkg::FN_UPDATE) ? new_rec : head;
						end
						// one-record lookahead so the final result carries last
						if (is_list && qual) begin
							if (have_q) begin
								status_q  <= okrt_pkg::ST_OK;
								key_q     <= hold_q.key;
								count_q   <= hold_q.count;
								last_q    <= 1'b0;
							end
							hold_q <= head;
							have_q <= 1'b1;
						end
						step_q <= step_q + 1'b1;
						if (step_q == IDX_W'(okrt_pkg::DEPTH - 1)) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (adv) begin
						last_q    <= 1'b1;
						state_q   <= S_IDLE;
						if (func_q == okrt_pkg::FN_APPEND) begin
							if (occ_q >= OCC_W'(okrt_pkg::DEPTH)) begin
								status_q <= okrt_pkg::ST_FULL;
								key_q    <= '0;
								count_q  <= '0;
							end else begin
								status_q <= okrt_pkg::ST_OK;
								key_q    <= nkey_q;
								count_q  <= ncnt_q;
								occ_q    <= occ_q + 1'b1;
							end
						end else if (is_srch) begin
							if (found_q) begin
								status_q <= okrt_pkg::ST_OK;
								key_q    <= frec_q.key;
								count_q  <= frec_q.count;
								if (func_q == okrt_pkg::FN_DELETE) begin
									occ_q <= occ_q - 1'b1;
								end
							end else begin
								status_q <= okrt_pkg::ST_NOT_FOUND;
								key_q    <= '0;
								count_q  <= '0;
							end
						end else begin
							if (have_q) begin
								status_q <= okrt_pkg::ST_OK;
								key_q    <= hold_q.key;
								count_q  <= hold_q.count;
							end else begin
								status_q <= okrt_pkg::ST_NONE;
								key_q    <= '0;
								count_q  <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;
	assign status    = status_q;
	assign rec_key   = key_q;
	assign rec_count = count_q;
	assign last      = last_q;

endmodule

// File: hw/rtl/ordered_keyed_record_table.sv
// Top level of the ordered keyed record table: sequencer plus a ring of record cells.
//
// Requests enter on in_valid/in_ready with func, search_key, new_key, new_count
// and threshold; results leave on out_valid/out_ready with status, rec_key,
// rec_count and last. last marks the final result of a request.
// Records sit in a ring of DEPTH cells; cell 0 is the head. Every request with a
// used code walks the whole ring once, one record per cycle while the result
// register is not stalled, each record re-entering at the tail, so it returns in
// place. A delete then closes its gap at the finish step. A request is accepted,
// walked over the ring and finished; in_ready is high only between requests, so
// no new request is taken before the last is done. Dump and scan results appear
// during the walk, each loaded when the next qualifying record is seen, the last
// at the finish. Unused function codes are accepted and dropped with no result.
// A stalled receiver holds the result register, which halts the walk until it
// drains. Reset empties the table and clears any request in progress.
module ordered_keyed_record_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [15:0] search_key,
	input  logic [15:0] new_key,
	input  logic [15:0] new_count,
	input  logic [15:0] threshold,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] rec_key,
	output logic [15:0] rec_count,
	output logic        last
);

	okrt_pkg::rec_t                cell_q [okrt_pkg::DEPTH];
	okrt_pkg::rec_t                push;
	logic [okrt_pkg::DEPTH-1:0]    shift_en;

	// Sequencer
	okrt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.search_key (search_key),
		.new_key    (new_key),
		.new_count  (new_count),
		.threshold  (threshold),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.rec_key    (rec_key),
		.rec_count  (rec_count),
		.last       (last),
		.head       (cell_q[0]),
		.push       (push),
		.shift_en   (shift_en)
	);

	// Ring of cells: each loads from its right neighbour, the tail from the sequencer
	for (genvar i = 0; i < okrt_pkg::DEPTH; i++) begin : g_cell
		if (i == okrt_pkg::DEPTH - 1) begin : g_tail
			okrt_cell u_cell (
				.clk   (clk),
				.shift (shift_en[i]),
				.din   (push),
				.dout  (cell_q[i])
			);
		end else begin : g_body
			okrt_cell u_cell (
				.clk   (clk),
				.shift (shift_en[i]),
				.din   (cell_q[i+1]),
				.dout  (cell_q[i])
			);
		end
	end

endmodule

// File: hw/rtl/okrt_checker.sv
// Port-level checks for the ordered keyed record table, bound to the top level.
`include "ordered_keyed_record_table_macros.svh"

module okrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  func,
	input logic [15:0] search_key,
	input logic [15:0] new_key,
	input logic [15:0] new_count,
	input logic [15:0] threshold,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] rec_key,
	input logic [15:0] rec_count,
	input logic        last
);

	// a stalled result holds
	`OKRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(rec_key) && $stable(rec_count) && $stable(last), "result changed while stalled")

	// a real request keeps the block busy for its walk
	`OKRT_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready && (func <= okrt_pkg::FN_SCAN), !in_ready, "block ready right after a request")

	// anything but a found record is a lone result
	`OKRT_ASSERT_NOW(a_status_last, out_valid && (status != okrt_pkg::ST_OK), last, "non-record status without last")

	// statuses without a record carry zero fields
	`OKRT_ASSERT_NOW(a_status_zero, out_valid && (status != okrt_pkg::ST_OK), (rec_key == 16'd0) && (rec_count == 16'd0), "non-record status with record data")

endmodule

bind ordered_keyed_record_table okrt_checker u_okrt_checker (.*);

// File: tb/ordered_keyed_record_table_test.sv
// Self-checking testbench for the ordered keyed record table: directed, stall and random traffic.
module ordered_keyed_record_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Function codes the block accepts and drops
	localparam logic [2:0] FN_SPARE_A = 3'd6;
	localparam logic [2:0] FN_SPARE_B = 3'd7;

	// One result as it leaves the block
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] key;
		logic [15:0] count;
		logic        last;
	} table_result_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [2:0]  func       = okrt_pkg::FN_LOOKUP;
	logic [15:0] search_key = '0;
	logic [15:0] new_key    = '0;
	logic [15:0] new_count  = '0;
	logic [15:0] threshold  = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [1:0]  status;
	logic [15:0] rec_key;
	logic [15:0] rec_count;
	logic        last;

	// Predicted table contents, in insertion order
	okrt_pkg::rec_t stored [okrt_pkg::DEPTH];
	int             table_used = 0;
	bit             growing    = 1'b1;
	table_result_t  awaited_results [$];

	int error_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_off_len   = 0;

	ordered_keyed_record_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.search_key (search_key),
		.new_key    (new_key),
		.new_count  (new_count),
		.threshold  (threshold),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.rec_key    (rec_key),
		.rec_count  (rec_count),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, well beyond the slowest correct run
	initial begin
		#5ms;
		$display("ordered_keyed_record_table_test failed");
		$finish;
	end

	// Receiver: random stalls, or a long hold-off when one is requested
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				hold_left    = hold_off_len;
				hold_off_len = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic void expect_result(input logic [1:0] st, input logic [15:0] k,
			input logic [15:0] c, input logic lst);
		table_result_t r;
		r.status = st;
		r.key    = k;
		r.count  = c;
		r.last   = lst;
		awaited_results.push_back(r);
	endfunction

	// Apply one accepted request to the predicted table and queue its results
	function automatic void apply_to_table(input logic [2:0] fn, input logic [15:0] skey,
			input logic [15:0] nkey, input logic [15:0] ncnt, input logic [15:0] thr);
		int            pos;
		int            hits;
		table_result_t tail;
		pos = table_used;
		for (int i = table_used - 1; i >= 0; i--)
			if (stored[i].key == skey)
				pos = i;
		unique case (fn)
			okrt_pkg::FN_APPEND: begin
				if (table_used >= okrt_pkg::DEPTH) begin
					expect_result(okrt_pkg::ST_FULL, '0, '0, 1'b1);
				end else begin
					stored[table_used] = '{key: nkey, count: ncnt};
					table_used++;
					expect_result(okrt_pkg::ST_OK, nkey, ncnt, 1'b1);
				end
			end
			okrt_pkg::FN_DELETE: begin
				if (pos == table_used) begin
					expect_result(okrt_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					expect_result(okrt_pkg::ST_OK, stored[pos].key, stored[pos].count, 1'b1);
					for (int i = pos; i < table_used - 1; i++)
						stored[i] = stored[i + 1];
					table_used--;
				end
			end
			okrt_pkg::FN_UPDATE, okrt_pkg::FN_LOOKUP: begin
				if (pos == table_used) begin
					expect_result(okrt_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					if (fn == okrt_pkg::FN_UPDATE)
						stored[pos] = '{key: nkey, count: ncnt};
					expect_result(okrt_pkg::ST_OK, stored[pos].key, stored[pos].count, 1'b1);
				end
			end
			okrt_pkg::FN_DUMP, okrt_pkg::FN_SCAN: begin
				hits = 0;
				for (int i = 0; i < table_used; i++) begin
					if (fn == okrt_pkg::FN_DUMP || stored[i].count <= thr) begin
						expect_result(okrt_pkg::ST_OK, stored[i].key, stored[i].count, 1'b0);
						hits++;
					end
				end
				if (hits == 0) begin
					expect_result(okrt_pkg::ST_NONE, '0, '0, 1'b1);
				end else begin
					tail      = awaited_results.pop_back();
					tail.last = 1'b1;
					awaited_results.push_back(tail);
				end
			end
			default: ;
		endcase
	endfunction

	// Key bias: mostly keys already held, so searches hit
	function automatic logic [15:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 55 && table_used > 0)
			return stored[$urandom_range(table_used - 1)].key;
		if (r < 80)
			return 16'($urandom_range(7));
		if (r < 85)
			return 16'h0000;
		if (r < 90)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_threshold();
		int r;
		r = $urandom_range(99);
		if (r < 30 && table_used > 0)
			return stored[$urandom_range(table_used - 1)].count;
		if (r < 40)
			return 16'h0000;
		if (r < 50)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// Offer one request and wait for it to be taken; valid stays high afterwards
	task automatic send_request(input logic [2:0] fn, input logic [15:0] skey,
			input logic [15:0] nkey, input logic [15:0] ncnt, input logic [15:0] thr);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= fn;
		search_key <= skey;
		new_key    <= nkey;
		new_count  <= ncnt;
		threshold  <= thr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_to_table(fn, skey, nkey, ncnt, thr);
	endtask

	// Sender pauses until every awaited result has arrived
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Result checker: each result against the oldest expectation
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: status %0d key %h count %h last %0d",
					status, rec_key, rec_count, last);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (rec_key !== want.key) begin
					$error("rec_key: expected %h, got %h", want.key, rec_key);
					error_count++;
				end
				if (rec_count !== want.count) begin
					$error("rec_count: expected %h, got %h", want.count, rec_count);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					error_count++;
				end
			end
		end
	end

	// Every request kind but append against an empty table
	task automatic test_empty_table();
		send_request(okrt_pkg::FN_DUMP,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_SCAN,   16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		send_request(okrt_pkg::FN_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_DELETE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_UPDATE, 16'h0000, 16'h1111, 16'h2222, 16'h0000);
		wait_all_results();
	endtask

	// Duplicates, first-match rules, scan edges and gap closing
	task automatic test_basic_ops();
		send_request(okrt_pkg::FN_APPEND, 16'h0000, 16'h0000, 16'h0005, 16'h0000);
		send_request(okrt_pkg::FN_APPEND, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_request(okrt_pkg::FN_APPEND, 16'h0000, 16'h0000, 16'h1234, 16'h0000);
		// records present but none at or below zero
		send_request(okrt_pkg::FN_SCAN,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_UPDATE, 16'h0000, 16'hA5A5, 16'h0000, 16'h0000);
		// the duplicate is now the first match
		send_request(okrt_pkg::FN_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_SCAN,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_SCAN,   16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		send_request(okrt_pkg::FN_DUMP,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// middle record removed, gap closed
		send_request(okrt_pkg::FN_DELETE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_DUMP,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_UPDATE, 16'hBEEF, 16'h1234, 16'h5678, 16'h0000);
		send_request(okrt_pkg::FN_DELETE, 16'h5A5A, 16'h0000, 16'h0000, 16'h0000);
		wait_all_results();
	endtask

	// Spare codes must leave the table untouched and produce nothing
	task automatic test_ignored_codes();
		send_request(FN_SPARE_A,        16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(FN_SPARE_B,        16'hA5A5, 16'h5A5A, 16'h0001, 16'h0000);
		send_request(okrt_pkg::FN_DUMP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		wait_all_results();
	endtask

	// Fill to capacity, overflow, full dump, then remove head and tail, refill and scan
	task automatic test_full_table();
		while (table_used < okrt_pkg::DEPTH)
			send_request(okrt_pkg::FN_APPEND, pick_key(), pick_key(), 16'($urandom),
				pick_threshold());
		send_request(okrt_pkg::FN_APPEND, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_request(okrt_pkg::FN_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_DUMP,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_SCAN,   16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		send_request(okrt_pkg::FN_DELETE, stored[0].key, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_DELETE, stored[table_used - 1].key,
			16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_APPEND, 16'h0000, 16'h8001, 16'h7FFE, 16'h0000);
		send_request(okrt_pkg::FN_APPEND, 16'h0000, 16'h7FFE, 16'h8001, 16'h0000);
		send_request(okrt_pkg::FN_APPEND, 16'h0000, 16'h0001, 16'h0001, 16'h0000);
		send_request(okrt_pkg::FN_SCAN,   16'h0000, 16'h0000, 16'h0000, pick_threshold());
		wait_all_results();
	endtask

	// Long receiver hold-off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_len   = 400;
		send_request(okrt_pkg::FN_DUMP,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_DUMP,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_LOOKUP, pick_key(), 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_SCAN,   16'h0000, 16'h0000, 16'h0000, pick_threshold());
		send_request(okrt_pkg::FN_DELETE, pick_key(), 16'h0000, 16'h0000, 16'h0000);
		send_request(okrt_pkg::FN_APPEND, 16'h0000, pick_key(), 16'($urandom), 16'h0000);
		send_request(okrt_pkg::FN_UPDATE, pick_key(), pick_key(), 16'($urandom), 16'h0000);
		wait_all_results();
	endtask

	// Random requests, drifting between filling and emptying the table
	task automatic test_random_traffic(input int n_req, input int send_pct, input int recv_pct);
		int         done;
		int         r;
		logic [2:0] fn;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		done = 0;
		while (done < n_req) begin
			if (table_used == okrt_pkg::DEPTH && $urandom_range(3) == 0)
				growing = 1'b0;
			if (table_used == 0)
				growing = 1'b1;
			r = $urandom_range(99);
			if (r < 2)
				fn = $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
			else if (r < (growing ? 52 : 10))
				fn = okrt_pkg::FN_APPEND;
			else if (r < 60)
				fn = okrt_pkg::FN_DELETE;
			else if (r < 70)
				fn = okrt_pkg::FN_UPDATE;
			else if (r < 80)
				fn = okrt_pkg::FN_LOOKUP;
			else if (r < 89)
				fn = okrt_pkg::FN_DUMP;
			else
				fn = okrt_pkg::FN_SCAN;
			send_request(fn, pick_key(), pick_key(), 16'($urandom), pick_threshold());
			if (fn != FN_SPARE_A && fn != FN_SPARE_B)
				done++;
		end
		wait_all_results();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_basic_ops();
		test_ignored_codes();
		test_full_table();
		test_backpressure();
		test_random_traffic(100, 0, 0);
		test_random_traffic(100, 86, 0);
		test_random_traffic(100, 0, 86);
		test_random_traffic(100, 19, 19);
		wait_all_results();
		repeat (okrt_pkg::DEPTH + 8) @(posedge clk);
		if (error_count == 0)
			$display("ordered_keyed_record_table_test passed");
		else
			$display("ordered_keyed_record_table_test failed");
		$finish;
	end

endmodule

// File: ordered_keyed_record_table.f
+incdir+hw/rtl
hw/rtl/okrt_pkg.sv
hw/rtl/okrt_cell.sv
hw/rtl/okrt_ctrl.sv
hw/rtl/ordered_keyed_record_table.sv
hw/rtl/okrt_checker.sv
tb/ordered_keyed_record_table_test.sv
